### design/fisheye_point_projection_defines.svh
// Assertion macros shared by the fisheye projection RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef FISHEYE_POINT_PROJECTION_DEFINES_SVH
`define FISHEYE_POINT_PROJECTION_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define FPP_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication that checks the consequent a fixed number of cycles later.
`define FPP_ASSERT_DELAY(label, clk, rst, ante, dly, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
      else $error(msg);

`endif

### design/fpp_pkg.sv
// Types and constants for the fisheye point projection pipeline.
// No dependencies; imported by every module of the block.
package fpp_pkg;

   localparam int SQRT_STEPS   = 32;
   localparam int CORDIC_STEPS = 31;
   localparam int ACC_W        = 42;
   localparam int PROD_W       = ACC_W + 17;

   localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
   localparam logic [31:0] ONE_Q30     = 32'd1073741824;

   localparam logic [31:0] DIST_COEF_1_RESET = 32'd107374182;
   localparam logic [31:0] DIST_COEF_2_RESET = 32'd21474836;
   localparam logic [31:0] DIST_COEF_3_RESET = 32'd10737418;
   localparam logic [31:0] DIST_COEF_4_RESET = 32'd5368709;
   localparam logic [31:0] FOCAL_X_RESET     = 32'd19660800;
   localparam logic [31:0] FOCAL_Y_RESET     = 32'd19660800;
   localparam logic [31:0] CENTER_X_RESET    = 32'd20971520;
   localparam logic [31:0] CENTER_Y_RESET    = 32'd15728640;

   localparam logic [31:0] ATAN_Q30 [CORDIC_STEPS] = '{
      32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
      32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
      32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
      32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256,
      32'd128, 32'd64, 32'd32, 32'd16, 32'd8, 32'd4, 32'd2, 32'd1
   };

   typedef enum logic [2:0] {
      CSR_DIST_COEF_1 = 3'd0,
      CSR_DIST_COEF_2 = 3'd1,
      CSR_DIST_COEF_3 = 3'd2,
      CSR_DIST_COEF_4 = 3'd3,
      CSR_FOCAL_X     = 3'd4,
      CSR_FOCAL_Y     = 3'd5,
      CSR_CENTER_X    = 3'd6,
      CSR_CENTER_Y    = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pixel_u;
      logic signed [31:0] pixel_v;
      logic               visible;
   } rsp_type;

   typedef struct packed {
      logic visible;
      logic on_axis;
      logic neg_x;
      logic neg_y;
   } flag_type;

   typedef struct packed {
      logic [63:0] rem;
      logic [63:0] root;
      logic [31:0] mag_x;
      logic [31:0] mag_y;
      logic [31:0] mag_z;
      flag_type    flags;
   } sqrt_state_type;

   typedef struct packed {
      logic [63:0] cx;
      logic [63:0] cy;
      logic [31:0] angle;
      logic [31:0] rho;
      logic [63:0] rem_x;
      logic [63:0] rem_y;
      logic [30:0] quo_x;
      logic [30:0] quo_y;
      flag_type    flags;
   } cordic_state_type;

   typedef struct packed {
      logic [31:0] theta_sq;
      logic [30:0] theta;
      logic [30:0] quo_x;
      logic [30:0] quo_y;
      flag_type    flags;
   } post_side_type;

   // Saturate a wide signed value to signed 32 bits.
   function automatic logic [31:0] sat_q16(input logic [ACC_W-1:0] v);
      logic [31:0] r;
      if (!v[ACC_W-1] && (|v[ACC_W-2:31])) begin
         r = 32'h7FFF_FFFF;
      end else if (v[ACC_W-1] && !(&v[ACC_W-2:31])) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

### design/fpp_sqrt_cell.sv
// One digit step of the bit-pair integer square root row.
// Depends on fpp_pkg for the carried state type.
module fpp_sqrt_cell #(
   parameter int STEP = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  fpp_pkg::sqrt_state_type in_state,
   output logic                   out_valid,
   output fpp_pkg::sqrt_state_type out_state
);
   import fpp_pkg::*;

   localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

   logic [63:0]    trial;
   logic           fits;
   sqrt_state_type state_in, state_ff;
   logic           valid_ff;

   always_comb begin
      state_in = in_state;
      trial    = in_state.root + BIT;
      fits     = in_state.rem >= trial;
      if (fits) begin
         state_in.rem  = in_state.rem - trial;
         state_in.root = (in_state.root >> 1) + BIT;
      end else begin
         state_in.root = in_state.root >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      state_ff <= state_in;
   end

   assign out_valid = valid_ff;
   assign out_state = state_ff;

endmodule

### design/fpp_cordic_cell.sv
// One CORDIC vectoring step plus one restoring-division bit for both axes.
// Depends on fpp_pkg for the angle table and the carried state type.
module fpp_cordic_cell #(
   parameter int STEP = 0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  fpp_pkg::cordic_state_type in_state,
   output logic                     out_valid,
   output fpp_pkg::cordic_state_type out_state
);
   import fpp_pkg::*;

   localparam int          QBIT  = 30 - STEP;
   localparam logic [31:0] ANGLE = ATAN_Q30[STEP];

   logic [63:0]      shift_x, shift_y, divisor;
   logic             fits_x, fits_y;
   cordic_state_type state_in, state_ff;
   logic             valid_ff;

   always_comb begin
      state_in = in_state;
      shift_x  = $signed(in_state.cx) >>> STEP;
      shift_y  = $signed(in_state.cy) >>> STEP;
      // rotate toward the x axis
      if (!in_state.cy[63]) begin
         state_in.cx    = in_state.cx + shift_y;
         state_in.cy    = in_state.cy - shift_x;
         state_in.angle = in_state.angle + ANGLE;
      end else begin
         state_in.cx    = in_state.cx - shift_y;
         state_in.cy    = in_state.cy + shift_x;
         state_in.angle = in_state.angle - ANGLE;
      end
      divisor = {32'd0, in_state.rho} << QBIT;
      fits_x  = in_state.rem_x >= divisor;
      fits_y  = in_state.rem_y >= divisor;
      if (fits_x) begin
         state_in.rem_x = in_state.rem_x - divisor;
      end
      if (fits_y) begin
         state_in.rem_y = in_state.rem_y - divisor;
      end
      state_in.quo_x[QBIT] = fits_x;
      state_in.quo_y[QBIT] = fits_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      state_ff <= state_in;
   end

   assign out_valid = valid_ff;
   assign out_state = state_ff;

endmodule

### design/fpp_mac_cell.sv
// Two-stage fixed-point multiply-add cell: out = coef + a*b with Q30 scaling.
// Depends on fpp_pkg for widths and the sideband type.
module fpp_mac_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic [fpp_pkg::ACC_W-1:0]   in_a,
   input  logic [31:0]                 in_b,
   input  logic [fpp_pkg::ACC_W-1:0]   in_coef,
   input  fpp_pkg::post_side_type      in_side,
   output logic                        out_valid,
   output logic [fpp_pkg::ACC_W-1:0]   out_acc,
   output fpp_pkg::post_side_type      out_side
);
   import fpp_pkg::*;

   logic signed [16:0]       b_hi, b_lo;
   logic signed [PROD_W-1:0] prod_hi_in, prod_lo_in, prod_hi_ff, prod_lo_ff;
   logic signed [PROD_W-1:0] sum;
   logic [ACC_W-1:0]         coef_ff, acc_in, acc_ff;
   post_side_type            side_a_ff, side_b_ff;
   logic                     valid_a_ff, valid_b_ff;

   assign b_hi       = $signed({1'b0, in_b[31:16]});
   assign b_lo       = $signed({1'b0, in_b[15:0]});
   assign prod_hi_in = $signed(in_a) * b_hi;
   assign prod_lo_in = $signed(in_a) * b_lo;

   always_comb begin
      sum    = PROD_W'($signed(coef_ff)) + (prod_hi_ff >>> 14) + (prod_lo_ff >>> 30);
      acc_in = sum[ACC_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else begin
         valid_a_ff <= in_valid;
         valid_b_ff <= valid_a_ff;
      end
      prod_hi_ff <= prod_hi_in;
      prod_lo_ff <= prod_lo_in;
      coef_ff    <= in_coef;
      side_a_ff  <= in_side;
      acc_ff     <= acc_in;
      side_b_ff  <= side_a_ff;
   end

   assign out_valid = valid_b_ff;
   assign out_acc   = acc_ff;
   assign out_side  = side_b_ff;

endmodule

### design/fisheye_point_projection.sv
// Top level of the fisheye (Kannala-Brandt) point projection pipeline.
// Depends on fpp_pkg, fpp_sqrt_cell, fpp_cordic_cell, fpp_mac_cell and the defines header.
`include "fisheye_point_projection_defines.svh"

// Fully pipelined: a point is taken on every clock where start is high and busy is low,
// and its pixel later appears on rsp_data with a one-cycle rsp_valid strobe. The result
// is never held, so the receiver must take it in that cycle. Each point passes through
// the 32-cell square root row, the 31-cell CORDIC/divider row and seven two-stage
// multiply-add cells in series for the distortion polynomial and pixel scaling. busy is
// high only during reset. Write csr_* registers only while no point is in flight.
module fisheye_point_projection (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  fpp_pkg::req_type req_data,
   output logic             rsp_valid,
   output fpp_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [2:0]       csr_index,
   input  logic [31:0]      csr_wdata
);
   import fpp_pkg::*;

   localparam int LATENCY = 5 + SQRT_STEPS + CORDIC_STEPS + 1 + 14 + 1;

   // configuration registers
   logic [31:0] coef1_ff, coef2_ff, coef3_ff, coef4_ff;
   logic [31:0] focal_x_ff, focal_y_ff, center_x_ff, center_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef1_ff    <= DIST_COEF_1_RESET;
         coef2_ff    <= DIST_COEF_2_RESET;
         coef3_ff    <= DIST_COEF_3_RESET;
         coef4_ff    <= DIST_COEF_4_RESET;
         focal_x_ff  <= FOCAL_X_RESET;
         focal_y_ff  <= FOCAL_Y_RESET;
         center_x_ff <= CENTER_X_RESET;
         center_y_ff <= CENTER_Y_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_DIST_COEF_1: coef1_ff    <= csr_wdata;
            CSR_DIST_COEF_2: coef2_ff    <= csr_wdata;
            CSR_DIST_COEF_3: coef3_ff    <= csr_wdata;
            CSR_DIST_COEF_4: coef4_ff    <= csr_wdata;
            CSR_FOCAL_X:     focal_x_ff  <= csr_wdata;
            CSR_FOCAL_Y:     focal_y_ff  <= csr_wdata;
            CSR_CENTER_X:    center_x_ff <= csr_wdata;
            CSR_CENTER_Y:    center_y_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign busy = reset;

   // front end: magnitudes, squares, axis test, normalization
   logic        v0_ff, v1_ff, v2_ff, v3_ff, v4_ff;
   logic [31:0] ax0_ff, ay0_ff, az0_ff, ax1_ff, ay1_ff, az1_ff;
   logic [31:0] ax2_ff, ay2_ff, az2_ff, ax3_ff, ay3_ff, az3_ff;
   flag_type    fl0_in, fl0_ff, fl1_ff, fl2_in, fl2_ff, fl3_ff;
   logic [63:0] sqx1_ff, sqy1_ff, sqz1_ff, px3_ff, py3_ff, rr;
   logic [31:0] mag_max;
   logic [4:0]  msb, sh_in, sh1_ff;
   sqrt_state_type sq4_in, sq4_ff;

   always_comb begin
      fl0_in.visible = !req_data.point_z[31] && (req_data.point_z != 32'sd0);
      fl0_in.on_axis = 1'b0;
      fl0_in.neg_x   = req_data.point_x[31];
      fl0_in.neg_y   = req_data.point_y[31];
   end

   always_comb begin
      mag_max = (ax0_ff > ay0_ff) ? ax0_ff : ay0_ff;
      if (az0_ff > mag_max) begin
         mag_max = az0_ff;
      end
      msb = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (mag_max[i]) begin
            msb = 5'(i);
         end
      end
      sh_in = (msb >= 5'd30) ? 5'd0 : 5'd30 - msb;
   end

   always_comb begin
      rr             = sqx1_ff + sqy1_ff;
      fl2_in         = fl1_ff;
      fl2_in.on_axis = (rr < 64'd4194304) && ({rr[23:0], 40'd0} < sqz1_ff);
   end

   always_comb begin
      sq4_in.rem   = px3_ff + py3_ff;
      sq4_in.root  = 64'd0;
      sq4_in.mag_x = ax3_ff;
      sq4_in.mag_y = ay3_ff;
      sq4_in.mag_z = az3_ff;
      sq4_in.flags = fl3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v0_ff <= start && !busy;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      ax0_ff  <= req_data.point_x[31] ? 32'(-req_data.point_x) : req_data.point_x;
      ay0_ff  <= req_data.point_y[31] ? 32'(-req_data.point_y) : req_data.point_y;
      az0_ff  <= req_data.point_z;
      fl0_ff  <= fl0_in;
      sqx1_ff <= ax0_ff * ax0_ff;
      sqy1_ff <= ay0_ff * ay0_ff;
      sqz1_ff <= az0_ff * az0_ff;
      sh1_ff  <= sh_in;
      ax1_ff  <= ax0_ff;
      ay1_ff  <= ay0_ff;
      az1_ff  <= az0_ff;
      fl1_ff  <= fl0_ff;
      ax2_ff  <= ax1_ff << sh1_ff;
      ay2_ff  <= ay1_ff << sh1_ff;
      az2_ff  <= az1_ff << sh1_ff;
      fl2_ff  <= fl2_in;
      px3_ff  <= ax2_ff * ax2_ff;
      py3_ff  <= ay2_ff * ay2_ff;
      ax3_ff  <= ax2_ff;
      ay3_ff  <= ay2_ff;
      az3_ff  <= az2_ff;
      fl3_ff  <= fl2_ff;
      sq4_ff  <= sq4_in;
   end

   // square root row
   logic           sq_v  [SQRT_STEPS+1];
   sqrt_state_type sq_st [SQRT_STEPS+1];

   assign sq_v[0]  = v4_ff;
   assign sq_st[0] = sq4_ff;

   for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
      fpp_sqrt_cell #(.STEP(g)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (sq_v[g]),
         .in_state  (sq_st[g]),
         .out_valid (sq_v[g+1]),
         .out_state (sq_st[g+1])
      );
   end

   // CORDIC angle and direction cosine row
   logic             cd_v  [CORDIC_STEPS+1];
   cordic_state_type cd_st [CORDIC_STEPS+1];
   sqrt_state_type   sq_last;

   always_comb begin
      sq_last               = sq_st[SQRT_STEPS];
      cd_st[0].rho          = sq_last.root[31:0];
      cd_st[0].cx           = {8'd0, sq_last.mag_z, 24'd0};
      cd_st[0].cy           = {8'd0, sq_last.root[31:0], 24'd0};
      cd_st[0].angle        = 32'd0;
      cd_st[0].rem_x        = {2'd0, sq_last.mag_x, 30'd0};
      cd_st[0].rem_y        = {2'd0, sq_last.mag_y, 30'd0};
      cd_st[0].quo_x        = 31'd0;
      cd_st[0].quo_y        = 31'd0;
      cd_st[0].flags        = sq_last.flags;
      // zero radius after rounding falls back to the principal point
      cd_st[0].flags.on_axis = sq_last.flags.on_axis || (sq_last.root[31:0] == 32'd0);
   end

   assign cd_v[0] = sq_v[SQRT_STEPS];

   for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
      fpp_cordic_cell #(.STEP(g)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (cd_v[g]),
         .in_state  (cd_st[g]),
         .out_valid (cd_v[g+1]),
         .out_state (cd_st[g+1])
      );
   end

   // clamp theta and square it
   cordic_state_type cd_last;
   logic [30:0]      theta;
   logic [61:0]      theta_prod;
   post_side_type    side_in, side_ff;
   logic             p0_valid_ff;

   always_comb begin
      cd_last = cd_st[CORDIC_STEPS];
      if (cd_last.angle[31]) begin
         theta = 31'd0;
      end else if (cd_last.angle[30:0] > HALF_PI_Q30) begin
         theta = HALF_PI_Q30;
      end else begin
         theta = cd_last.angle[30:0];
      end
      theta_prod       = theta * theta;
      side_in.theta_sq = theta_prod[61:30];
      side_in.theta    = theta;
      side_in.quo_x    = cd_last.quo_x;
      side_in.quo_y    = cd_last.quo_y;
      side_in.flags    = cd_last.flags;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_valid_ff <= 1'b0;
      end else begin
         p0_valid_ff <= cd_v[CORDIC_STEPS];
      end
      side_ff <= side_in;
   end

   // distortion polynomial (Horner), then theta_d, then pixel scaling
   logic             h_v    [6];
   logic [ACC_W-1:0] h_acc  [6];
   post_side_type    h_side [6];
   logic [ACC_W-1:0] h_a    [5];
   logic [31:0]      h_b    [5];
   logic [ACC_W-1:0] h_coef [5];

   always_comb begin
      h_v[0]    = p0_valid_ff;
      h_acc[0]  = ACC_W'($signed(coef4_ff));
      h_side[0] = side_ff;
      for (int i = 0; i < 4; i++) begin
         h_a[i] = h_acc[i];
         h_b[i] = h_side[i].theta_sq;
      end
      h_coef[0] = ACC_W'($signed(coef3_ff));
      h_coef[1] = ACC_W'($signed(coef2_ff));
      h_coef[2] = ACC_W'($signed(coef1_ff));
      h_coef[3] = ACC_W'(ONE_Q30);
      h_a[4]    = h_acc[4];
      h_b[4]    = {1'b0, h_side[4].theta};
      h_coef[4] = '0;
   end

   for (genvar g = 0; g < 5; g++) begin : g_poly
      fpp_mac_cell u_mac (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (h_v[g]),
         .in_a      (h_a[g]),
         .in_b      (h_b[g]),
         .in_coef   (h_coef[g]),
         .in_side   (h_side[g]),
         .out_valid (h_v[g+1]),
         .out_acc   (h_acc[g+1]),
         .out_side  (h_side[g+1])
      );
   end

   logic             dx_v;
   logic [ACC_W-1:0] dx_acc, dy_acc, ux_a, vy_a, u_acc, v_acc;
   post_side_type    dx_side, u_side;
   logic             u_v;

   fpp_mac_cell u_mac_dx (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (h_v[5]),
      .in_a      (h_acc[5]),
      .in_b      ({1'b0, h_side[5].quo_x}),
      .in_coef   ('0),
      .in_side   (h_side[5]),
      .out_valid (dx_v),
      .out_acc   (dx_acc),
      .out_side  (dx_side)
   );

   fpp_mac_cell u_mac_dy (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (h_v[5]),
      .in_a      (h_acc[5]),
      .in_b      ({1'b0, h_side[5].quo_y}),
      .in_coef   ('0),
      .in_side   (h_side[5]),
      .out_valid (),
      .out_acc   (dy_acc),
      .out_side  ()
   );

   assign ux_a = dx_side.flags.neg_x ? ACC_W'(-dx_acc) : dx_acc;
   assign vy_a = dx_side.flags.neg_y ? ACC_W'(-dy_acc) : dy_acc;

   fpp_mac_cell u_mac_u (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dx_v),
      .in_a      (ux_a),
      .in_b      (focal_x_ff),
      .in_coef   (ACC_W'(center_x_ff)),
      .in_side   (dx_side),
      .out_valid (u_v),
      .out_acc   (u_acc),
      .out_side  (u_side)
   );

   fpp_mac_cell u_mac_v (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dx_v),
      .in_a      (vy_a),
      .in_b      (focal_y_ff),
      .in_coef   (ACC_W'(center_y_ff)),
      .in_side   (dx_side),
      .out_valid (),
      .out_acc   (v_acc),
      .out_side  ()
   );

   // result register
   rsp_type rsp_in, rsp_ff;
   logic    rsp_valid_ff;

   always_comb begin
      rsp_in.visible = u_side.flags.visible;
      priority if (!u_side.flags.visible) begin
         rsp_in.pixel_u = 32'sd0;
         rsp_in.pixel_v = 32'sd0;
      end else if (u_side.flags.on_axis) begin
         rsp_in.pixel_u = sat_q16(ACC_W'(center_x_ff));
         rsp_in.pixel_v = sat_q16(ACC_W'(center_y_ff));
      end else begin
         rsp_in.pixel_u = sat_q16(u_acc);
         rsp_in.pixel_v = sat_q16(v_acc);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= u_v;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `FPP_ASSERT_DELAY(a_accept_to_result, clock, reset, start && !busy, LATENCY, rsp_valid, "accepted transaction produced no result at the pipeline depth")
   `FPP_ASSERT_IMPLY(a_result_has_source, clock, reset, rsp_valid, $past(start && !busy, LATENCY), "result without an accepted transaction")
   `FPP_ASSERT_IMPLY(a_hidden_is_zero, clock, reset, rsp_valid && !rsp_data.visible, (rsp_data.pixel_u == 32'sd0) && (rsp_data.pixel_v == 32'sd0), "point behind camera gave nonzero pixels")

endmodule

### sim/tb_top.sv
// Self-checking testbench for the fisheye point projection pipeline.
// Depends on fpp_pkg and fisheye_point_projection; predicts each pixel in fixed point.
`timescale 1ns / 1ps

module tb_top;
   import fpp_pkg::*;

   class projection_scoreboard;
      rsp_type pending_pixels[$];
      int      error_count;
      logic [31:0] coef[4];
      logic [31:0] focal_u, focal_v, center_u, center_v;

      function new();
         error_count = 0;
         coef[0] = DIST_COEF_1_RESET;
         coef[1] = DIST_COEF_2_RESET;
         coef[2] = DIST_COEF_3_RESET;
         coef[3] = DIST_COEF_4_RESET;
         focal_u = FOCAL_X_RESET;
         focal_v = FOCAL_Y_RESET;
         center_u = CENTER_X_RESET;
         center_v = CENTER_Y_RESET;
      endfunction

      function void write_register(csr_index_type idx, logic [31:0] value);
         case (idx)
            CSR_DIST_COEF_1: coef[0] = value;
            CSR_DIST_COEF_2: coef[1] = value;
            CSR_DIST_COEF_3: coef[2] = value;
            CSR_DIST_COEF_4: coef[3] = value;
            CSR_FOCAL_X:     focal_u = value;
            CSR_FOCAL_Y:     focal_v = value;
            CSR_CENTER_X:    center_u = value;
            CSR_CENTER_Y:    center_v = value;
         endcase
      endfunction

      // Floor shift; >>> on a signed longint floors already.
      function longint shr_floor(longint a, int s);
         return a >>> s;
      endfunction

      // Q30 multiply by an unsigned 32-bit value, split into high and low halves.
      function longint scale_q30(longint a, logic [31:0] b);
         longint hi, lo;
         hi = a * longint'({32'd0, b[31:16]});
         lo = a * longint'({48'd0, b[15:0]});
         return shr_floor(hi, 14) + shr_floor(lo, 30);
      endfunction

      function logic [31:0] clamp32(longint v);
         if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
         if (v < -64'sd2147483648) return 32'h8000_0000;
         return v[31:0];
      endfunction

      function logic [63:0] int_sqrt(logic [63:0] n);
         logic [63:0] res, bit_w;
         res = 0;
         bit_w = 64'd1 << 62;
         while (bit_w > n) bit_w >>= 2;
         while (bit_w != 0) begin
            if (n >= res + bit_w) begin
               n -= res + bit_w;
               res = (res >> 1) + bit_w;
            end else begin
               res >>= 1;
            end
            bit_w >>= 2;
         end
         return res;
      endfunction

      function longint axis_coord(longint thd, logic [63:0] mag, logic [63:0] rho, bit neg,
                                  logic [31:0] focal, logic [31:0] center);
         logic [63:0] cos_q;
         longint d;
         cos_q = (mag << 30) / rho;
         d = scale_q30(thd, cos_q[31:0]);
         if (neg) d = -d;
         return scale_q30(d, focal) + longint'({32'd0, center});
      endfunction

      function rsp_type project_point(req_type p);
         rsp_type r;
         longint px, py, pz, cx, cy, ang, acc, poly, thd;
         logic [63:0] ax, ay, az, m, rr, zz, rho, sq;
         px = p.point_x;
         py = p.point_y;
         pz = p.point_z;
         r = '0;
         if (pz <= 0) return r;
         r.visible = 1'b1;
         ax = px < 0 ? -px : px;
         ay = py < 0 ? -py : py;
         az = pz;
         rr = ax * ax + ay * ay;
         zz = az * az;
         if (rr < (64'd1 << 22) && (rr << 40) < zz) begin
            r.pixel_u = clamp32(longint'({32'd0, center_u}));
            r.pixel_v = clamp32(longint'({32'd0, center_v}));
            return r;
         end
         m = ax > ay ? ax : ay;
         if (az > m) m = az;
         while (m < (64'd1 << 30)) begin
            m <<= 1; ax <<= 1; ay <<= 1; az <<= 1;
         end
         rho = int_sqrt(ax * ax + ay * ay);
         if (rho == 0) begin
            r.pixel_u = clamp32(longint'({32'd0, center_u}));
            r.pixel_v = clamp32(longint'({32'd0, center_v}));
            return r;
         end
         // CORDIC vectoring for atan2(rho, z)
         cx = az << 24;
         cy = rho << 24;
         ang = 0;
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            longint dx, dy;
            dx = cx >>> i;
            dy = cy >>> i;
            if (cy >= 0) begin
               cx += dy; cy -= dx; ang += ATAN_Q30[i];
            end else begin
               cx -= dy; cy += dx; ang -= ATAN_Q30[i];
            end
         end
         if (ang < 0) ang = 0;
         if (ang > HALF_PI_Q30) ang = HALF_PI_Q30;
         sq = (ang * ang) >> 30;
         acc = longint'(signed'(coef[3]));
         acc = longint'(signed'(coef[2])) + scale_q30(acc, sq[31:0]);
         acc = longint'(signed'(coef[1])) + scale_q30(acc, sq[31:0]);
         acc = longint'(signed'(coef[0])) + scale_q30(acc, sq[31:0]);
         poly = longint'(ONE_Q30) + scale_q30(acc, sq[31:0]);
         thd = scale_q30(poly, ang[31:0]);
         r.pixel_u = clamp32(axis_coord(thd, ax, rho, px < 0, focal_u, center_u));
         r.pixel_v = clamp32(axis_coord(thd, ay, rho, py < 0, focal_v, center_v));
         return r;
      endfunction

      function void note_point(req_type p);
         pending_pixels = {pending_pixels, project_point(p)};
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         $display("mismatch %s: got %h expected %h", what, got, want);
         error_count++;
      endtask

      task check_pixel(rsp_type got);
         rsp_type want;
         if (pending_pixels.size() == 0) begin
            report("unexpected transaction", got.pixel_u, 32'd0);
            return;
         end
         want = pending_pixels.pop_front();
         if (got.pixel_u !== want.pixel_u) report("pixel_u", got.pixel_u, want.pixel_u);
         if (got.pixel_v !== want.pixel_v) report("pixel_v", got.pixel_v, want.pixel_v);
         if (got.visible !== want.visible) begin
            report("visible", {31'd0, got.visible}, {31'd0, want.visible});
         end
      endtask
   endclass

   localparam int LATENCY = 84;

   logic    clock, reset, start, busy, rsp_valid, csr_we;
   req_type req_data;
   rsp_type rsp_data;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;

   projection_scoreboard pixel_board;

   fisheye_point_projection dut (.*);

   always begin
      clock = 1'b1; #10;
      clock = 1'b0; #10;
   end

   always @(posedge clock) begin
      if (!reset && start && !busy) pixel_board.note_point(req_data);
      if (!reset && rsp_valid) pixel_board.check_pixel(rsp_data);
   end

   // One write per call; csr_we is dropped again before the task returns.
   task automatic write_register(csr_index_type idx, logic [31:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      pixel_board.write_register(idx, value);
      @(negedge clock);
   endtask

   task automatic drain_pipeline();
      while (pixel_board.pending_pixels.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Present one point and hold it until the block takes it.
   task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      start <= 1'b1;
      req_data <= {x, y, z};
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic idle_cycles(int n);
      start <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   function automatic logic [31:0] random_coord(int kind);
      case (kind)
         0: return $urandom;
         1: return $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
         2: return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
         default: return $urandom_range(0, 15) - 8;
      endcase
   endfunction

   task automatic random_burst(int count);
      int burst;
      logic [31:0] z;
      burst = 0;
      for (int n = 0; n < count; n++) begin
         if (burst == 0) begin
            burst = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 12));
         end
         burst--;
         // mostly points in front of the camera
         z = ($urandom_range(0, 9) == 0) ? random_coord($urandom_range(0, 3))
                                        : $urandom_range(1, 32'h7FFF_FFFF) >> $urandom_range(0, 24);
         if (z == 0) z = 1;
         send_point(random_coord($urandom_range(0, 3)), random_coord($urandom_range(0, 3)), z);
      end
      idle_cycles(1);
   endtask

   task automatic random_registers();
      for (int i = 0; i < 4; i++)
         write_register(csr_index_type'(i), $urandom_range(0, 32'h0FFF_FFFF) - 32'h0800_0000);
      write_register(CSR_FOCAL_X, $urandom_range(0, 32'h0400_0000));
      write_register(CSR_FOCAL_Y, $urandom_range(0, 32'h0400_0000));
      write_register(CSR_CENTER_X, $urandom);
      write_register(CSR_CENTER_Y, $urandom);
   endtask

   initial begin
      pixel_board = new();
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: behind camera, on axis, extremes, quadrants, saturation
      send_point(32'd0, 32'd0, 32'd0);
      send_point(32'h0001_0000, 32'h0001_0000, 32'h8000_0000);
      send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
      send_point(32'd0, 32'd0, 32'h0001_0000);
      send_point(32'd1, 32'd0, 32'h7FFF_FFFF);
      send_point(32'd0, 32'd0, 32'd1);
      send_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
      send_point(32'hFFFF_0000, 32'h0001_0000, 32'h0001_0000);
      send_point(32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000);
      send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1);
      send_point(32'h8000_0000, 32'h8000_0000, 32'd1);
      send_point(32'hFFFF_FFFF, 32'd0, 32'h7FFF_FFFF);
      send_point(32'h0010_0000, 32'h0000_0000, 32'h7FFF_FFFF);
      send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      idle_cycles(1);
      drain_pipeline();

      // extreme register settings: negative polynomial, max focal and center on x, zero on y
      write_register(CSR_DIST_COEF_1, 32'h8000_0000);
      write_register(CSR_DIST_COEF_2, 32'h7FFF_FFFF);
      write_register(CSR_DIST_COEF_3, 32'h8000_0000);
      write_register(CSR_DIST_COEF_4, 32'h7FFF_FFFF);
      write_register(CSR_FOCAL_X, 32'hFFFF_FFFF);
      write_register(CSR_FOCAL_Y, 32'd0);
      write_register(CSR_CENTER_X, 32'hFFFF_FFFF);
      write_register(CSR_CENTER_Y, 32'd0);
      send_point(32'd0, 32'd0, 32'h0001_0000);
      send_point(32'h0001_0000, 32'hFFFF_0000, 32'h0000_1000);
      send_point(32'hFFFF_0000, 32'h0001_0000, 32'h0001_0000);
      send_point(32'h0100_0000, 32'h0100_0000, 32'h0000_0100);
      idle_cycles(1);
      drain_pipeline();

      write_register(CSR_DIST_COEF_1, 32'd0);
      write_register(CSR_DIST_COEF_2, 32'd0);
      write_register(CSR_DIST_COEF_3, 32'd0);
      write_register(CSR_DIST_COEF_4, 32'd0);
      write_register(CSR_FOCAL_X, 32'd0);
      write_register(CSR_FOCAL_Y, 32'hFFFF_FFFF);
      write_register(CSR_CENTER_X, 32'd0);
      write_register(CSR_CENTER_Y, 32'hFFFF_FFFF);
      random_burst(100);
      drain_pipeline();

      // back to the default lens, then a few random lenses
      write_register(CSR_DIST_COEF_1, DIST_COEF_1_RESET);
      write_register(CSR_DIST_COEF_2, DIST_COEF_2_RESET);
      write_register(CSR_DIST_COEF_3, DIST_COEF_3_RESET);
      write_register(CSR_DIST_COEF_4, DIST_COEF_4_RESET);
      write_register(CSR_FOCAL_X, FOCAL_X_RESET);
      write_register(CSR_FOCAL_Y, FOCAL_Y_RESET);
      write_register(CSR_CENTER_X, CENTER_X_RESET);
      write_register(CSR_CENTER_Y, CENTER_Y_RESET);
      random_burst(300);
      drain_pipeline();
      for (int k = 0; k < 3; k++) begin
         random_registers();
         random_burst(150);
         drain_pipeline();
      end

      repeat (LATENCY + 20) @(negedge clock);
      if (pixel_board.error_count == 0 && pixel_board.pending_pixels.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("Regression FAIL");
      $finish;
   end
endmodule
